[design/crs_block_element_lookup_top_defines.svh]
// assertion macros used by the element lookup back end
`ifndef CRS_BLOCK_ELEMENT_LOOKUP_TOP_DEFINES_SVH
`define CRS_BLOCK_ELEMENT_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define CRS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/crs_bel_pkg.sv]
// types and constants of the sparse block element lookup
package crs_bel_pkg;

    localparam logic [1:0] MODE_LOAD_ROW_START = 2'd0;
    localparam logic [1:0] MODE_LOAD_COLUMN    = 2'd1;
    localparam logic [1:0] MODE_READ           = 2'd2;
    localparam logic [1:0] MODE_WRITE          = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_MISS  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [1:0] REG_ROWS          = 2'd0;
    localparam logic [1:0] REG_DOF           = 2'd1;
    localparam logic [1:0] REG_BLOCK_ENTRIES = 2'd2;
    localparam logic [1:0] REG_SYMMETRIC     = 2'd3;

    localparam int CFG_DATA_W = 13;
    localparam logic [3:0] DIV_LAST = 4'd11;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] row_index;
        logic [11:0] col_index;
        logic [12:0] table_addr;
        logic [12:0] table_word;
        logic [63:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] flat_pos;
        logic [63:0] read_value;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [10:0] rows;
        logic [2:0]  dof;
        logic [12:0] block_entries;
        logic        symmetric;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_LOAD_ROW_START,
        CMD_LOAD_COLUMN,
        CMD_ACCESS,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        is_write;
        logic [11:0] gi;
        logic [11:0] gj;
        logic [12:0] table_addr;
        logic [12:0] table_word;
        logic [63:0] write_value;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_RS0,
        B_RS1,
        B_RS2,
        B_SRCH,
        B_CMP,
        B_BLK,
        B_FLAT,
        B_VAL,
        B_VWAIT,
        B_RESP
    } back_state_t;

endpackage

[design/crs_bel_front.sv]
// front end: classifies input items, range checks and index mirroring
module crs_bel_front #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_NNZ  = 4096,
    parameter int MAX_DOF  = 4
) (
    input  crs_bel_pkg::cfg_t     cfg,
    input  crs_bel_pkg::in_item_t in_item,
    output crs_bel_pkg::cmd_t     cmd
);
    import crs_bel_pkg::*;

    logic [13:0] side;
    logic        cfg_bad;
    logic        idx_bad;
    logic        swap;

    assign side    = 14'(cfg.rows) * 14'(cfg.dof);
    assign cfg_bad = (cfg.rows == 11'd0) || (32'(cfg.rows) > MAX_ROWS)
                  || (cfg.dof == 3'd0) || (32'(cfg.dof) > MAX_DOF);
    assign idx_bad = (14'(in_item.row_index) >= side) || (14'(in_item.col_index) >= side);
    assign swap    = cfg.symmetric && (in_item.row_index > in_item.col_index);

    always_comb
    begin
        cmd.is_write    = (in_item.mode == MODE_WRITE);
        cmd.gi          = swap ? in_item.col_index : in_item.row_index;
        cmd.gj          = swap ? in_item.row_index : in_item.col_index;
        cmd.table_addr  = in_item.table_addr;
        cmd.table_word  = in_item.table_word;
        cmd.write_value = in_item.write_value;
        case (in_item.mode)
            MODE_LOAD_ROW_START:
                cmd.kind = ((32'(in_item.table_addr) > MAX_ROWS)
                         || (32'(in_item.table_word) > MAX_NNZ))
                         ? CMD_REJECT : CMD_LOAD_ROW_START;
            MODE_LOAD_COLUMN:
                cmd.kind = ((32'(in_item.table_addr) >= MAX_NNZ)
                         || (32'(in_item.table_word) >= MAX_ROWS))
                         ? CMD_REJECT : CMD_LOAD_COLUMN;
            default:
                cmd.kind = (cfg_bad || idx_bad) ? CMD_REJECT : CMD_ACCESS;
        endcase
    end

endmodule

[design/crs_bel_fifo.sv]
// two-entry command queue between front and back
module crs_bel_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  crs_bel_pkg::cmd_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output crs_bel_pkg::cmd_t rd_data,
    output logic              empty
);
    import crs_bel_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[design/crs_bel_back.sv]
// back end: divider, row search, flat index and value store
`include "crs_block_element_lookup_top_defines.svh"
module crs_bel_back #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_NNZ  = 4096,
    parameter int MAX_DOF  = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crs_bel_pkg::cfg_t      cfg,
    input  crs_bel_pkg::cmd_t      cmd_head,
    input  logic                   cmd_empty,
    output logic                   cmd_pop,
    output crs_bel_pkg::out_item_t out_item,
    output logic                   empty,
    input  logic                   pop
);
    import crs_bel_pkg::*;

    localparam int ROW_DEPTH = MAX_ROWS + 1;
    localparam int RA_W      = $clog2(ROW_DEPTH);
    localparam int NNZ_AW    = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int COL_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RS_W      = $clog2(MAX_NNZ + 1);
    localparam int VAL_DEPTH = MAX_DOF * MAX_DOF * MAX_NNZ;
    localparam int VAL_AW    = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
    localparam int FLAT_W    = 32;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [11:0] dvd_i_reg, dvd_j_reg, rem_i_reg, rem_j_reg;
    logic [3:0]  div_cnt_reg;
    logic [RS_W-1:0] lo_reg, hi_reg, mid_reg, mid_calc;
    logic [5:0]  blk_reg;
    logic [FLAT_W-1:0] flat_reg;
    out_item_t   res_reg, out_reg;
    logic        out_valid_reg, out_valid_next;

    logic [RS_W-1:0]  rs_mem [ROW_DEPTH];
    logic [RS_W-1:0]  rs_q;
    logic [COL_W-1:0] col_mem [MAX_NNZ];
    logic [COL_W-1:0] col_q;
    logic [63:0]      val_mem [VAL_DEPTH];
    logic [63:0]      val_q;

    logic rs_we, rs_re, col_we, col_re, val_we, val_re;
    logic [RA_W-1:0]   rs_raddr;
    logic [11:0]       sh_i, sh_j;
    logic              ge_i, ge_j;
    logic              key_hit, key_lt, flat_bad, out_load;

    assign sh_i     = {rem_i_reg[10:0], dvd_i_reg[11]};
    assign sh_j     = {rem_j_reg[10:0], dvd_j_reg[11]};
    assign ge_i     = sh_i >= {1'b0, cfg.rows};
    assign ge_j     = sh_j >= {1'b0, cfg.rows};
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key_hit  = 32'(col_q) == 32'(rem_j_reg);
    assign key_lt   = 32'(rem_j_reg) < 32'(col_q);
    assign flat_bad = flat_reg >= FLAT_W'(VAL_DEPTH);
    assign out_load = (state_reg == B_RESP) && (!out_valid_reg || pop);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!cmd_empty)
                    state_next = (cmd_head.kind == CMD_ACCESS) ? B_DIV : B_RESP;
            B_DIV:
                if (div_cnt_reg == DIV_LAST)
                    state_next = B_RS0;
            B_RS0:  state_next = B_RS1;
            B_RS1:  state_next = B_RS2;
            B_RS2:  state_next = B_SRCH;
            B_SRCH: state_next = (lo_reg < hi_reg) ? B_CMP : B_RESP;
            B_CMP:  state_next = key_hit ? B_BLK : B_SRCH;
            B_BLK:  state_next = B_FLAT;
            B_FLAT: state_next = B_VAL;
            B_VAL:  state_next = (flat_bad || cmd_reg.is_write) ? B_RESP : B_VWAIT;
            B_VWAIT: state_next = B_RESP;
            B_RESP:
                if (out_load)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_pop  = (state_reg == B_IDLE) && !cmd_empty;
        rs_we    = cmd_pop && (cmd_head.kind == CMD_LOAD_ROW_START);
        col_we   = cmd_pop && (cmd_head.kind == CMD_LOAD_COLUMN);
        rs_re    = (state_reg == B_RS0) || (state_reg == B_RS1);
        rs_raddr = (state_reg == B_RS0) ? RA_W'(rem_i_reg) : RA_W'(13'(rem_i_reg) + 13'd1);
        col_re   = (state_reg == B_SRCH) && (lo_reg < hi_reg);
        val_we   = (state_reg == B_VAL) && !flat_bad && cmd_reg.is_write;
        val_re   = (state_reg == B_VAL) && !flat_bad && !cmd_reg.is_write;
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[RA_W'(cmd_head.table_addr)] <= RS_W'(cmd_head.table_word);
        if (rs_re)
            rs_q <= rs_mem[rs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[NNZ_AW'(cmd_head.table_addr)] <= COL_W'(cmd_head.table_word);
        if (col_re)
            col_q <= col_mem[NNZ_AW'(mid_calc)];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[VAL_AW'(flat_reg)] <= cmd_reg.write_value;
        if (val_re)
            val_q <= val_mem[VAL_AW'(flat_reg)];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                cmd_reg     <= cmd_head;
                dvd_i_reg   <= cmd_head.gi;
                dvd_j_reg   <= cmd_head.gj;
                rem_i_reg   <= 12'd0;
                rem_j_reg   <= 12'd0;
                div_cnt_reg <= 4'd0;
                res_reg.found       <= 1'b0;
                res_reg.flat_pos    <= 16'd0;
                res_reg.read_value  <= 64'd0;
                res_reg.status      <= (cmd_head.kind == CMD_REJECT) ? STATUS_RANGE : STATUS_OK;
            end
            B_DIV:
            begin
                // restoring division, one quotient bit per cycle in each lane
                dvd_i_reg   <= {dvd_i_reg[10:0], ge_i};
                dvd_j_reg   <= {dvd_j_reg[10:0], ge_j};
                rem_i_reg   <= ge_i ? sh_i - {1'b0, cfg.rows} : sh_i;
                rem_j_reg   <= ge_j ? sh_j - {1'b0, cfg.rows} : sh_j;
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            B_RS1: lo_reg <= rs_q;
            B_RS2: hi_reg <= rs_q;
            B_SRCH:
            begin
                mid_reg <= mid_calc;
                if (!(lo_reg < hi_reg))
                    res_reg.status <= STATUS_MISS;
            end
            B_CMP:
                if (!key_hit)
                begin
                    if (key_lt)
                        hi_reg <= mid_reg;
                    else
                        lo_reg <= mid_reg + RS_W'(1);
                end
            B_BLK:
                blk_reg <= 6'(dvd_i_reg[2:0]) * 6'(cfg.dof) + 6'(dvd_j_reg[2:0]);
            B_FLAT:
                flat_reg <= FLAT_W'(blk_reg) * FLAT_W'(cfg.block_entries) + FLAT_W'(mid_reg);
            B_VAL:
                if (flat_bad)
                    res_reg.status <= STATUS_RANGE;
                else
                begin
                    res_reg.found       <= 1'b1;
                    res_reg.flat_pos    <= flat_reg[15:0];
                    res_reg.read_value  <= cmd_reg.write_value;
                    res_reg.status      <= STATUS_OK;
                end
            B_VWAIT: res_reg.read_value <= val_q;
            default: ;
        endcase
    end

    // output register: a finished result waits here while the next item starts
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res_reg;
    end

    assign out_item = out_reg;
    assign empty    = !out_valid_reg;

    `CRS_ASSERT_IMP(a_found_ok, out_valid_reg && out_reg.found, out_reg.status == STATUS_OK)
    `CRS_ASSERT_NXT(a_cmp_next, state_reg == B_CMP, state_reg == B_SRCH || state_reg == B_BLK)
    `CRS_ASSERT_NXT(a_div_done, state_reg == B_DIV && div_cnt_reg == DIV_LAST, state_reg == B_RS0)
    `CRS_ASSERT_NXT(a_resp_load, state_reg == B_RESP && !out_valid_reg, out_valid_reg)

endmodule

[design/crs_block_element_lookup_top.sv]
// top level of the sparse block element lookup
//  channel | direction | transfer condition
//  in      | into      | push && !full
//  out     | out of    | pop && !empty
//  cfg     | into      | cfg_write (no wait)
// an access takes the command, runs the divider, reads the row starts, makes
// binary-search probes of the column table, then forms the index, reaches the
// value store and responds; a search makes up to 13 probes. a miss skips the
// index and the value store. loads and rejected items go from the command
// straight to the response.
// a two-entry command queue lets items arrive while the back end works, and
// one output register holds a result until it is popped.
// reset clears control state only; the tables hold nothing until loaded.
module crs_block_element_lookup_top #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_NNZ  = 4096,
    parameter int MAX_DOF  = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  crs_bel_pkg::in_item_t   in_item,
    output logic                    empty,
    input  logic                    pop,
    output crs_bel_pkg::out_item_t  out_item,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [crs_bel_pkg::CFG_DATA_W-1:0] cfg_data
);
    import crs_bel_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd, head_cmd;
    logic cmd_empty, cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows          <= 11'd1;
            cfg_reg.dof           <= 3'd1;
            cfg_reg.block_entries <= 13'd0;
            cfg_reg.symmetric     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROWS:          cfg_reg.rows          <= cfg_data[10:0];
                REG_DOF:           cfg_reg.dof           <= cfg_data[2:0];
                REG_BLOCK_ENTRIES: cfg_reg.block_entries <= cfg_data[12:0];
                REG_SYMMETRIC:     cfg_reg.symmetric     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    crs_bel_front #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_NNZ (MAX_NNZ),
        .MAX_DOF (MAX_DOF)
    ) u_front (
        .cfg    (cfg_reg),
        .in_item(in_item),
        .cmd    (front_cmd)
    );

    crs_bel_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_data(front_cmd),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_data(head_cmd),
        .empty  (cmd_empty)
    );

    crs_bel_back #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_NNZ (MAX_NNZ),
        .MAX_DOF (MAX_DOF)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd_head (head_cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

[tb/element_lookup_checker.sv]
// checker: predicts each lookup result and compares it with what the block returns
module element_lookup_checker
    import crs_bel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_item_t              in_item,
    input  logic                  empty,
    input  logic                  pop,
    input  out_item_t             out_item,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);
    localparam int ROW_LIMIT   = 1024;
    localparam int NNZ_LIMIT   = 4096;
    localparam int DOF_LIMIT   = 4;
    localparam int STORE_DEPTH = 65536;

    logic [12:0] row_start [0:ROW_LIMIT];
    logic [9:0]  column [0:NNZ_LIMIT-1];
    logic [63:0] store [0:STORE_DEPTH-1];
    cfg_t        cfg;
    out_item_t   expected_q[$];

    function automatic out_item_t lookup_element(in_item_t it);
        out_item_t r;
        int gi, gj, swap_tmp, nrows, ndof, side;
        int ir, jr, bi, bj, lo, hi, mid, flat;
        bit hit;
        r = '0;
        r.status = STATUS_OK;
        if (it.mode == MODE_LOAD_ROW_START)
        begin
            if (it.table_addr > ROW_LIMIT || it.table_word > NNZ_LIMIT)
                r.status = STATUS_RANGE;
            else
                row_start[it.table_addr] = it.table_word;
            return r;
        end
        if (it.mode == MODE_LOAD_COLUMN)
        begin
            if (it.table_addr >= NNZ_LIMIT || it.table_word >= ROW_LIMIT)
                r.status = STATUS_RANGE;
            else
                column[it.table_addr] = it.table_word[9:0];
            return r;
        end
        nrows = int'(cfg.rows);
        ndof = int'(cfg.dof);
        if (nrows == 0 || nrows > ROW_LIMIT || ndof == 0 || ndof > DOF_LIMIT)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        side = nrows * ndof;
        gi = int'(it.row_index);
        gj = int'(it.col_index);
        if (gi >= side || gj >= side)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        // upper triangle only when symmetric
        if (cfg.symmetric && gi > gj)
        begin
            swap_tmp = gi;
            gi = gj;
            gj = swap_tmp;
        end
        ir = gi % nrows;
        jr = gj % nrows;
        bi = gi / nrows;
        bj = gj / nrows;
        lo = int'(row_start[ir]);
        hi = int'(row_start[ir + 1]);
        if (hi > NNZ_LIMIT)
            hi = NNZ_LIMIT;
        hit = 1'b0;
        mid = 0;
        while (lo < hi && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            if (int'(column[mid]) == jr)
                hit = 1'b1;
            else if (jr < int'(column[mid]))
                hi = mid;
            else
                lo = mid + 1;
        end
        if (!hit)
        begin
            r.status = STATUS_MISS;
            return r;
        end
        flat = (bi * ndof + bj) * int'(cfg.block_entries) + mid;
        if (flat >= STORE_DEPTH)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        if (it.mode == MODE_WRITE)
            store[flat] = it.write_value;
        r.found = 1'b1;
        r.flat_pos = flat[15:0];
        r.read_value = store[flat];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            cfg = '{rows: 11'd1, dof: 3'd1, block_entries: 13'd0, symmetric: 1'b0};
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ROWS:          cfg.rows = cfg_data[10:0];
                    REG_DOF:           cfg.dof = cfg_data[2:0];
                    REG_BLOCK_ENTRIES: cfg.block_entries = cfg_data[12:0];
                    REG_SYMMETRIC:     cfg.symmetric = cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full)
                expected_q.push_back(lookup_element(in_item));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                                                  out_item.found, want.found));
                    if (out_item.flat_pos !== want.flat_pos)
                        report_mismatch($sformatf("flat_pos %0d, want %0d",
                                                  out_item.flat_pos, want.flat_pos));
                    if (out_item.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  out_item.read_value, want.read_value));
                    if (out_item.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  out_item.status, want.status));
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

[tb/testbench.sv]
// testbench top: drives pattern loads and element accesses into the lookup block
module testbench;
    import crs_bel_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    in_item_t              in_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = REG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;

    int          send_idle_pct = 10;
    int          recv_idle_pct = 63;
    logic [12:0] rs_copy [0:1024];
    logic [9:0]  col_copy [0:4095];
    int          nnz;
    int          pat_row[$];
    int          pat_pos[$];

    crs_block_element_lookup_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    element_lookup_checker lookup_check (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);

    initial
    begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

    function automatic in_item_t random_item();
        in_item_t it;
        it.mode = 2'($urandom);
        it.row_index = 12'($urandom);
        it.col_index = 12'($urandom);
        it.table_addr = 13'($urandom);
        it.table_word = 13'($urandom);
        it.write_value = {$urandom, $urandom};
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_load(logic [1:0] mode, int addr, int word);
        in_item_t it;
        it = random_item();
        it.mode = mode;
        it.table_addr = 13'(addr);
        it.table_word = 13'(word);
        send_item(it);
    endtask

    task automatic send_access(logic [1:0] mode, int gi, int gj, logic [63:0] value);
        in_item_t it;
        it = random_item();
        it.mode = mode;
        it.row_index = 12'(gi);
        it.col_index = 12'(gj);
        it.write_value = value;
        send_item(it);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_config(int nrows, int ndof, int stride, int sym);
        cfg_write <= 1'b1;
        cfg_index <= REG_ROWS;
        cfg_data <= CFG_DATA_W'(nrows);
        @(posedge clk);
        cfg_index <= REG_DOF;
        cfg_data <= CFG_DATA_W'(ndof);
        @(posedge clk);
        cfg_index <= REG_BLOCK_ENTRIES;
        cfg_data <= CFG_DATA_W'(stride);
        @(posedge clk);
        cfg_index <= REG_SYMMETRIC;
        cfg_data <= CFG_DATA_W'(sym);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // random sorted columns per row (unsorted swaps the first and last column); large row counts keep most rows empty
    task automatic build_pattern(int nrows, bit unsorted, bit inverted);
        int c, cnt;
        logic [9:0] tmp;
        nnz = 0;
        for (int r = 0; r < nrows; r++)
        begin
            rs_copy[r] = 13'(nnz);
            if (nrows <= 64 || $urandom_range(0, 99) < 2)
            begin
                c = $urandom_range(0, (nrows - 1) / 2);
                cnt = 0;
                while (c < nrows && cnt < 3 && nnz < 24)
                begin
                    col_copy[nnz] = 10'(c);
                    nnz++;
                    cnt++;
                    c += 1 + $urandom_range(0, nrows / 3);
                end
            end
        end
        rs_copy[nrows] = 13'(nnz);
        if (unsorted && nnz >= 3)
        begin
            tmp = col_copy[0];
            col_copy[0] = col_copy[nnz - 1];
            col_copy[nnz - 1] = tmp;
        end
        // row 1 becomes empty or inverted, row 0 then spans the whole table
        if (inverted && nrows >= 2)
            rs_copy[1] = 13'(nnz);
        pat_row.delete();
        pat_pos.delete();
        for (int r = 0; r < nrows; r++)
            for (int k = int'(rs_copy[r]); k < int'(rs_copy[r + 1]); k++)
            begin
                pat_row.push_back(r);
                pat_pos.push_back(k);
            end
        for (int a = 0; a <= nrows; a++)
            send_load(MODE_LOAD_ROW_START, a, int'(rs_copy[a]));
        for (int a = 0; a < nnz; a++)
            send_load(MODE_LOAD_COLUMN, a, int'(col_copy[a]));
    endtask

    // write every reachable element once so later reads never see unwritten words
    task automatic fill_values(int nrows, int ndof);
        for (int bi = 0; bi < ndof; bi++)
            for (int bj = 0; bj < ndof; bj++)
                for (int e = 0; e < pat_row.size(); e++)
                    send_access(MODE_WRITE, bi * nrows + pat_row[e],
                                bj * nrows + int'(col_copy[pat_pos[e]]), {$urandom, $urandom});
    endtask

    task automatic pattern_access(logic [1:0] mode, int nrows, int ndof, int e,
                                  logic [63:0] value);
        send_access(mode, $urandom_range(0, ndof - 1) * nrows + pat_row[e],
                    $urandom_range(0, ndof - 1) * nrows + int'(col_copy[pat_pos[e]]), value);
    endtask

    task automatic random_step(int nrows, int ndof);
        int sel, side, a;
        logic [1:0] mode;
        side = nrows * ndof;
        sel = $urandom_range(0, 99);
        mode = ($urandom_range(0, 99) < 35) ? MODE_WRITE : MODE_READ;
        if (sel < 45 && pat_row.size() > 0)
            pattern_access(mode, nrows, ndof, $urandom_range(0, pat_row.size() - 1),
                           {$urandom, $urandom});
        else if (sel < 70)
            send_access(mode, $urandom_range(0, side - 1), $urandom_range(0, side - 1),
                        {$urandom, $urandom});
        else if (sel < 80)
            send_access(mode, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        {$urandom, $urandom});
        else if (sel < 88)
            // column words past the pattern are never searched
            send_load(MODE_LOAD_COLUMN, $urandom_range(nnz, 4095), $urandom_range(0, 1023));
        else if (sel < 94)
        begin
            case ($urandom_range(0, 3))
                0: send_load(MODE_LOAD_ROW_START, $urandom_range(1025, 8191),
                             $urandom_range(0, 8191));
                1: send_load(MODE_LOAD_ROW_START, $urandom_range(0, 1024),
                             $urandom_range(4097, 8191));
                2: send_load(MODE_LOAD_COLUMN, $urandom_range(4096, 8191),
                             $urandom_range(0, 8191));
                default: send_load(MODE_LOAD_COLUMN, $urandom_range(0, 4095),
                                   $urandom_range(1024, 8191));
            endcase
        end
        else
        begin
            a = $urandom_range(0, nrows);
            send_load(MODE_LOAD_ROW_START, a, int'(rs_copy[a]));
        end
    endtask

    task automatic directed_items(int nrows, int ndof);
        int side, last;
        side = nrows * ndof;
        last = pat_row.size() - 1;
        send_load(MODE_LOAD_ROW_START, 1024, 4096);
        send_load(MODE_LOAD_ROW_START, 1025, 0);
        send_load(MODE_LOAD_ROW_START, 0, 4097);
        send_load(MODE_LOAD_ROW_START, 8191, 8191);
        send_load(MODE_LOAD_COLUMN, 4095, 1023);
        send_load(MODE_LOAD_COLUMN, 4096, 0);
        send_load(MODE_LOAD_COLUMN, 0, 1024);
        send_access(MODE_READ, 4095, 4095, '0);
        send_access(MODE_READ, 0, 4095, '0);
        send_access(MODE_WRITE, 4095, 0, '1);
        send_access(MODE_READ, side, 0, '0);
        send_access(MODE_READ, 0, 0, '0);
        send_access(MODE_READ, side - 1, side - 1, '0);
        send_access(MODE_WRITE, side - 1, 0, '1);
        send_access(MODE_WRITE, 0, side - 1, '1);
        send_access(MODE_WRITE, pat_row[0], int'(col_copy[pat_pos[0]]), '1);
        send_access(MODE_READ, pat_row[0], int'(col_copy[pat_pos[0]]), '0);
        send_access(MODE_WRITE, pat_row[last], int'(col_copy[pat_pos[last]]), '0);
        send_access(MODE_READ, pat_row[last], int'(col_copy[pat_pos[last]]), '1);
        pattern_access(MODE_WRITE, nrows, ndof, last, 64'h8000_0000_0000_0001);
    endtask

    initial
    begin
        int p_rows [12] = '{1, 4, 4, 64, 7, 0, 2047, 3, 3, 16, 5, 2};
        int p_dof [12] = '{1, 4, 4, 1, 3, 2, 1, 0, 7, 2, 2, 4};
        int p_stride [12] = '{0, -1, -1, 4096, 8191, 5, 3, 2, 2, -1, 0, 3};
        int p_sym [12] = '{0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0, 1};
        int p_unsorted [12] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0};
        int p_inverted [12] = '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0};
        int p_count [12] = '{20, 30, 30, 20, 20, 5, 5, 5, 5, 30, 20, 20};
        bit valid;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 10;
            end
            else if (ph == 9)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            valid = p_rows[ph] >= 1 && p_rows[ph] <= 1024 && p_dof[ph] >= 1 && p_dof[ph] <= 4;
            if (ph > 0)
                wait_idle();
            if (valid)
                build_pattern(p_rows[ph], p_unsorted[ph], p_inverted[ph]);
            // config changes only with nothing in flight
            if (ph > 0)
            begin
                wait_idle();
                write_config(p_rows[ph], p_dof[ph],
                             (p_stride[ph] < 0) ? nnz : p_stride[ph], p_sym[ph]);
            end
            if (valid)
            begin
                fill_values(p_rows[ph], p_dof[ph]);
                if (ph == 1)
                    directed_items(p_rows[ph], p_dof[ph]);
                for (int n = 0; n < p_count[ph]; n++)
                    random_step(p_rows[ph], p_dof[ph]);
            end
            else
                for (int n = 0; n < p_count[ph]; n++)
                    send_item(random_item());
        end
        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/crs_bel_pkg.sv
design/crs_bel_front.sv
design/crs_bel_fifo.sv
design/crs_bel_back.sv
design/crs_block_element_lookup_top.sv
tb/element_lookup_checker.sv
tb/testbench.sv
